// ----- src/rlvd_pkg.sv -----
// Package: shared types, constants and register codes of the RMS level voice detector.
`timescale 1ns / 1ps
`default_nettype none

package rlvd_pkg;

    // Default buffer capacity in samples
    localparam int MAX_SAMPLES_DEF = 512;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 16;
    localparam int TIME_W   = 32;
    localparam int IDX_W    = 8;
    localparam int WDATA_W  = 32;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_DETECT_ENABLE  = 8'd0;
    localparam logic [IDX_W-1:0] CFG_DENOISE_ENABLE = 8'd1;
    localparam logic [IDX_W-1:0] CFG_VOICE_THRESH   = 8'd2;
    localparam logic [IDX_W-1:0] CFG_NOISE_FLOOR    = 8'd3;
    localparam logic [IDX_W-1:0] CFG_HOLD_MS        = 8'd4;

    // Configuration reset values
    localparam logic [LEVEL_W-1:0] THRESH_RST = 16'd1024;
    localparam logic [TIME_W-1:0]  HOLD_RST   = 32'd500;

    // Input sample request
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
        logic [TIME_W-1:0]          time_ms;
    } t_smp;

    // Level result request
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               voice_active;
        logic [TIME_W-1:0]  voice_duration_ms;
    } t_res;

    // Configuration write request
    typedef struct packed {
        logic [IDX_W-1:0]   reg_index;
        logic [WDATA_W-1:0] wdata;
    } t_cfg_req;

    // Configuration register contents
    typedef struct packed {
        logic               detect_enable;
        logic               denoise_enable;
        logic [LEVEL_W-1:0] voice_level_threshold;
        logic [LEVEL_W-1:0] noise_floor;
        logic [TIME_W-1:0]  hold_ms;
    } t_cfg;

    // Accumulator control from the sequencer
    typedef struct packed {
        logic load;
        logic add;
        logic clear;
    } t_acc_ctl;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ACCUM,
        S_LOAD,
        S_DIV,
        S_SQRT,
        S_TRIM,
        S_DECIDE
    } t_state;

endpackage

`default_nettype wire

// ----- src/rlvd_chan_if.sv -----
// Interface: valid/ready channel carrying one request of type T.
`timescale 1ns / 1ps
`default_nettype none

interface rlvd_chan_if #(parameter type T = logic [0:0]);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/rlvd_cfg.sv -----
// Configuration register file of the RMS level voice detector.
`timescale 1ns / 1ps
`default_nettype none

module rlvd_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rlvd_chan_if.sink     i_cfg,
    output rlvd_pkg::t_cfg o_cfg
);
    import rlvd_pkg::*;

    t_cfg r_cfg;

    // Writes are taken whenever out of reset
    assign i_cfg.ready = i_rst_n;
    assign o_cfg       = r_cfg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.detect_enable         <= 1'b0;
            r_cfg.denoise_enable        <= 1'b0;
            r_cfg.voice_level_threshold <= THRESH_RST;
            r_cfg.noise_floor           <= '0;
            r_cfg.hold_ms               <= HOLD_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.reg_index)
                CFG_DETECT_ENABLE:  r_cfg.detect_enable  <= i_cfg.data.wdata[0];
                CFG_DENOISE_ENABLE: r_cfg.denoise_enable <= i_cfg.data.wdata[0];
                CFG_VOICE_THRESH:
                    r_cfg.voice_level_threshold <= i_cfg.data.wdata[LEVEL_W-1:0];
                CFG_NOISE_FLOOR:    r_cfg.noise_floor <= i_cfg.data.wdata[LEVEL_W-1:0];
                CFG_HOLD_MS:        r_cfg.hold_ms     <= i_cfg.data.wdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/rlvd_acc.sv -----
// Square-and-accumulate stage: sum of squared sample magnitudes and sample count.
`timescale 1ns / 1ps
`default_nettype none

module rlvd_acc #(
    parameter  int MAX_SAMPLES = rlvd_pkg::MAX_SAMPLES_DEF,
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1),
    localparam int SUM_W       = 31 + $clog2(MAX_SAMPLES)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  rlvd_pkg::t_acc_ctl                     i_ctl,
    input  logic signed [rlvd_pkg::SAMPLE_W-1:0]   i_sample,
    output logic [SUM_W-1:0]                       o_sum,
    output logic [CNT_W-1:0]                       o_count
);
    import rlvd_pkg::*;

    logic [SAMPLE_W-1:0] w_raw;
    logic [SAMPLE_W-1:0] w_mag;
    logic [31:0]         w_prod;
    logic [SAMPLE_W-1:0] r_mag;
    logic [30:0]         r_sq;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_count;

    // Magnitude; the most negative sample maps to 32768
    assign w_raw  = i_sample;
    assign w_mag  = w_raw[SAMPLE_W-1] ? (~w_raw + 16'd1) : w_raw;
    assign w_prod = 32'(r_mag) * 32'(r_mag);

    assign o_sum   = r_sum;
    assign o_count = r_count;

    // Magnitude and square registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mag <= w_mag;
        end
        r_sq <= w_prod[30:0];
    end

    // Running sum; samples past capacity are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_ctl.clear) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_ctl.add && (r_count < CNT_W'(MAX_SAMPLES))) begin
            r_sum   <= r_sum + SUM_W'(r_sq);
            r_count <= r_count + 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- src/rlvd_alu.sv -----
// Shared subtract-and-compare unit used by the divide and square-root steps.
`timescale 1ns / 1ps
`default_nettype none

module rlvd_alu #(
    parameter int W = 24
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_diff,
    output logic         o_ge
);
    logic [W:0] w_full;

    // Borrow out of the top bit means a < b
    assign w_full = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_full[W-1:0];
    assign o_ge   = ~w_full[W];

endmodule

`default_nettype wire

// ----- src/rlvd_seq.sv -----
// Sequencer: sample handshake, restoring divide, bit-pair square root, voice decision.
`timescale 1ns / 1ps
`default_nettype none

module rlvd_seq #(
    parameter  int MAX_SAMPLES = rlvd_pkg::MAX_SAMPLES_DEF,
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1),
    localparam int SUM_W       = 31 + $clog2(MAX_SAMPLES),
    localparam int HALF_W      = (SUM_W + 1) / 2,
    localparam int REM_W       = (CNT_W > HALF_W + 1) ? CNT_W : HALF_W + 1,
    localparam int ALU_W       = REM_W + 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rlvd_chan_if.sink          i_smp,
    rlvd_chan_if.source        o_res,
    input  rlvd_pkg::t_cfg     i_cfg,
    input  logic [SUM_W-1:0]   i_sum,
    input  logic [CNT_W-1:0]   i_count,
    output rlvd_pkg::t_acc_ctl o_acc_ctl,
    output logic [ALU_W-1:0]   o_alu_a,
    output logic [ALU_W-1:0]   o_alu_b,
    input  logic [ALU_W-1:0]   i_alu_diff,
    input  logic               i_alu_ge
);
    import rlvd_pkg::*;

    localparam int RAD_W  = 2 * HALF_W;
    localparam int STEP_W = $clog2(RAD_W);

    t_state              r_state, n_state;
    t_acc_ctl            w_acc_ctl;
    logic                w_ready;
    logic                w_out_free;

    logic                r_last;
    logic [TIME_W-1:0]   r_time;
    logic [RAD_W-1:0]    r_quo;
    logic [REM_W-1:0]    r_rem;
    logic [CNT_W-1:0]    r_div;
    logic [HALF_W-1:0]   r_root;
    logic [STEP_W-1:0]   r_step;
    logic [LEVEL_W-1:0]  r_level;
    logic [TIME_W-1:0]   r_elapsed;
    logic [LEVEL_W:0]    w_trim;

    logic                r_voice, n_voice;
    logic [TIME_W-1:0]   r_onset, n_onset;
    logic [TIME_W-1:0]   r_duration, n_duration;
    logic                r_out_valid;
    t_res                r_out;

    assign i_smp.ready = w_ready & i_rst_n;
    assign o_acc_ctl   = w_acc_ctl;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;
    assign w_out_free  = ~r_out_valid | o_res.ready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and control
    always_comb begin
        n_state   = r_state;
        w_acc_ctl = '0;
        w_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_ready = 1'b1;
                if (i_smp.valid) begin
                    w_acc_ctl.load = 1'b1;
                    n_state        = S_SQUARE;
                end
            end
            S_SQUARE: n_state = S_ACCUM;
            S_ACCUM: begin
                w_acc_ctl.add = 1'b1;
                n_state       = r_last ? S_LOAD : S_IDLE;
            end
            S_LOAD: begin
                w_acc_ctl.clear = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (r_step == '0) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_step == '0) begin
                    n_state = S_TRIM;
                end
            end
            S_TRIM: n_state = S_DECIDE;
            S_DECIDE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Shared unit operands: quotient digit or root digit trial
    always_comb begin
        if (r_state == S_SQRT) begin
            o_alu_a = ALU_W'({r_rem[HALF_W:0], r_quo[RAD_W-1 -: 2]});
            o_alu_b = ALU_W'({r_root, 2'b01});
        end else begin
            o_alu_a = ALU_W'({r_rem[CNT_W-1:0], r_quo[RAD_W-1]});
            o_alu_b = ALU_W'(r_div);
        end
    end

    // Noise floor removal, clamped at zero
    assign w_trim = {1'b0, r_root[LEVEL_W-1:0]} - {1'b0, i_cfg.noise_floor};

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_smp.valid) begin
                    r_last <= i_smp.data.last_sample;
                    r_time <= i_smp.data.time_ms;
                end
            end
            S_LOAD: begin
                r_quo  <= RAD_W'(i_sum);
                r_rem  <= '0;
                r_div  <= i_count;
                r_step <= STEP_W'(RAD_W - 1);
            end
            S_DIV: begin
                r_quo <= {r_quo[RAD_W-2:0], i_alu_ge};
                r_rem <= i_alu_ge ? i_alu_diff[REM_W-1:0] : o_alu_a[REM_W-1:0];
                if (r_step == '0) begin
                    r_rem  <= '0;
                    r_root <= '0;
                    r_step <= STEP_W'(HALF_W - 1);
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
            S_SQRT: begin
                r_quo  <= {r_quo[RAD_W-3:0], 2'b00};
                r_rem  <= i_alu_ge ? i_alu_diff[REM_W-1:0] : o_alu_a[REM_W-1:0];
                r_root <= {r_root[HALF_W-2:0], i_alu_ge};
                r_step <= r_step - 1'b1;
            end
            S_TRIM: begin
                if (i_cfg.denoise_enable) begin
                    r_level <= w_trim[LEVEL_W] ? '0 : w_trim[LEVEL_W-1:0];
                end else begin
                    r_level <= r_root[LEVEL_W-1:0];
                end
                r_elapsed <= r_time - r_onset;
            end
            default: ;
        endcase
    end

    // Voice onset, hold and release decision
    always_comb begin
        n_voice    = r_voice;
        n_onset    = r_onset;
        n_duration = r_duration;
        if (i_cfg.detect_enable) begin
            if (r_level > i_cfg.voice_level_threshold) begin
                if (!r_voice) begin
                    n_voice    = 1'b1;
                    n_onset    = r_time;
                    n_duration = '0;
                end else begin
                    n_duration = r_elapsed;
                end
            end else if (r_voice && (r_elapsed > i_cfg.hold_ms)) begin
                n_voice    = 1'b0;
                n_duration = '0;
            end
        end
    end

    // Voice state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice     <= 1'b0;
            r_onset     <= '0;
            r_duration  <= '0;
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DECIDE) && w_out_free) begin
            r_voice     <= n_voice;
            r_onset     <= n_onset;
            r_duration  <= n_duration;
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DECIDE) && w_out_free) begin
            r_out.level             <= r_level;
            r_out.voice_active      <= n_voice;
            r_out.voice_duration_ms <= n_duration;
        end
    end

endmodule

`default_nettype wire

// ----- src/rms_level_voice_detector.sv -----
// Top level of the RMS level voice detector.
//
// Channels: i_smp takes samples (sample, last_sample, time_ms); o_res gives one
// result (level, voice_active, voice_duration_ms) per buffer; i_cfg writes the
// registers by index and is always ready out of reset. All use valid/ready; a
// request moves at a rising edge with both high.
// Sample flow: a sample that is not last is taken in S_IDLE, squared in S_SQUARE
// and added in S_ACCUM; i_smp is ready again in the cycle after accumulation.
// Result: after a last sample, S_LOAD, S_DIV, S_SQRT, S_TRIM and S_DECIDE put
// its result in the output register. The shared subtractor serves both steps:
// the divide takes one quotient bit a cycle over 2*H bits, the square root one
// root bit a cycle, with H = ceil((31 + clog2(MAX_SAMPLES)) / 2).
// Stall: the result waits in the output register; samples of the next buffer
// are taken meanwhile, and only the next result waits for it to drain.
// Reset (synchronous, active low) clears the accumulator, the voice state, the
// result valid and loads register defaults; both input channels hold ready low
// while it is asserted, so no request is taken and lost.
`timescale 1ns / 1ps
`default_nettype none

module rms_level_voice_detector #(
    parameter int MAX_SAMPLES = rlvd_pkg::MAX_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rlvd_chan_if.sink   i_smp,
    rlvd_chan_if.source o_res,
    rlvd_chan_if.sink   i_cfg
);
    import rlvd_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = 31 + $clog2(MAX_SAMPLES);
    localparam int HALF_W = (SUM_W + 1) / 2;
    localparam int REM_W  = (CNT_W > HALF_W + 1) ? CNT_W : HALF_W + 1;
    localparam int ALU_W  = REM_W + 2;

    t_cfg             w_cfg;
    t_acc_ctl         w_acc_ctl;
    logic [SUM_W-1:0] w_sum;
    logic [CNT_W-1:0] w_count;
    logic [ALU_W-1:0] w_alu_a;
    logic [ALU_W-1:0] w_alu_b;
    logic [ALU_W-1:0] w_alu_diff;
    logic             w_alu_ge;

    // Register file
    rlvd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // Square and accumulate
    rlvd_acc #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_acc_ctl),
        .i_sample (i_smp.data.sample),
        .o_sum    (w_sum),
        .o_count  (w_count)
    );

    // Shared subtractor
    rlvd_alu #(
        .W (ALU_W)
    ) u_alu (
        .i_a    (w_alu_a),
        .i_b    (w_alu_b),
        .o_diff (w_alu_diff),
        .o_ge   (w_alu_ge)
    );

    // Sequencer
    rlvd_seq #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (i_smp),
        .o_res      (o_res),
        .i_cfg      (w_cfg),
        .i_sum      (w_sum),
        .i_count    (w_count),
        .o_acc_ctl  (w_acc_ctl),
        .o_alu_a    (w_alu_a),
        .o_alu_b    (w_alu_b),
        .i_alu_diff (w_alu_diff),
        .i_alu_ge   (w_alu_ge)
    );

`ifndef SYNTH
    // Buffer count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(MAX_SAMPLES))
        else $error("sample count above capacity");

    // A taken sample keeps the sequencer busy for the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> !i_smp.ready)
        else $error("sample taken while previous one in progress");

    // Level never exceeds full scale
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.data.level <= 16'd32768))
        else $error("level above full scale");

    // No duration is reported while voice is inactive
    a_quiet_duration: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.data.voice_active) |->
            (o_res.data.voice_duration_ms == '0))
        else $error("duration nonzero without voice");
`endif

endmodule

`default_nettype wire
